// ===== hw/rtl/x86dec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package x86dec_pkg;

  localparam int REG_COUNT = 8;
  localparam int BUF_DEPTH = 6;

  // Instruction classes carried in op_class.
  localparam logic [3:0] CLS_RM_REG   = 4'd0;
  localparam logic [3:0] CLS_IMM_RM   = 4'd1;
  localparam logic [3:0] CLS_IMM_REG  = 4'd2;
  localparam logic [3:0] CLS_MEM_ACC  = 4'd3;
  localparam logic [3:0] CLS_ACC_MEM  = 4'd4;
  localparam logic [3:0] CLS_IMM_ACC  = 4'd5;
  localparam logic [3:0] CLS_JCC      = 4'd6;
  localparam logic [3:0] CLS_INVALID  = 4'd7;

  // Operation kinds carried in alu_kind.
  localparam logic [2:0] ALU_MOV   = 3'd0;
  localparam logic [2:0] ALU_ADD   = 3'd1;
  localparam logic [2:0] ALU_SUB   = 3'd2;
  localparam logic [2:0] ALU_CMP   = 3'd3;
  localparam logic [2:0] ALU_UNSUP = 3'd4;

  // Group selector values in the reg field of opcodes 80..83.
  localparam logic [2:0] GRP_ADD = 3'd0;
  localparam logic [2:0] GRP_SUB = 3'd5;
  localparam logic [2:0] GRP_CMP = 3'd7;

  // Opcode patterns, compared against the top bits of the opcode.
  localparam logic [5:0] OP6_MOV_RM   = 6'b100010;
  localparam logic [6:0] OP7_MOV_IRM  = 7'b1100011;
  localparam logic [3:0] OP4_MOV_IREG = 4'b1011;
  localparam logic [6:0] OP7_MEM_ACC  = 7'b1010000;
  localparam logic [6:0] OP7_ACC_MEM  = 7'b1010001;
  localparam logic [5:0] OP6_GRP_IMM  = 6'b100000;
  localparam logic [5:0] OP6_ADD_RM   = 6'b000000;
  localparam logic [5:0] OP6_SUB_RM   = 6'b001010;
  localparam logic [5:0] OP6_CMP_RM   = 6'b001110;
  localparam logic [6:0] OP7_ADD_ACC  = 7'b0000010;
  localparam logic [6:0] OP7_SUB_ACC  = 7'b0010110;
  localparam logic [6:0] OP7_CMP_ACC  = 7'b0011110;
  localparam logic [3:0] OP4_JCC      = 4'b0111;

  typedef logic [BUF_DEPTH-1:0][7:0] code_buf_t;

  typedef struct packed {
    logic [3:0]         op_class;
    logic [2:0]         alu_kind;
    logic               to_reg;
    logic               wide;
    logic [1:0]         mode;
    logic [3:0]         reg_code;
    logic [2:0]         rm_code;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [3:0]         jump_cond;
  } decode_rec_t;

  typedef struct packed {
    logic        valid;
    logic        wide;
    logic [2:0]  reg_sel;
    logic [15:0] data;
  } exec_req_t;

  function automatic logic [3:0] class_of(input logic [7:0] op);
    logic [3:0] cls;
    if (op[7:2] == OP6_MOV_RM) cls = CLS_RM_REG;
    else if (op[7:1] == OP7_MOV_IRM) cls = CLS_IMM_RM;
    else if (op[7:4] == OP4_MOV_IREG) cls = CLS_IMM_REG;
    else if (op[7:1] == OP7_MEM_ACC) cls = CLS_MEM_ACC;
    else if (op[7:1] == OP7_ACC_MEM) cls = CLS_ACC_MEM;
    else if (op[7:2] == OP6_GRP_IMM) cls = CLS_IMM_RM;
    else if (op[7:2] == OP6_ADD_RM || op[7:2] == OP6_SUB_RM || op[7:2] == OP6_CMP_RM)
      cls = CLS_RM_REG;
    else if (op[7:1] == OP7_ADD_ACC || op[7:1] == OP7_SUB_ACC || op[7:1] == OP7_CMP_ACC)
      cls = CLS_IMM_ACC;
    else if (op[7:4] == OP4_JCC) cls = CLS_JCC;
    else cls = CLS_INVALID;
    return cls;
  endfunction

  // Displacement bytes that follow a mod-reg-rm byte.
  function automatic logic [1:0] disp_count(input logic [7:0] modrm);
    logic [1:0] n;
    case (modrm[7:6])
      2'd0:    n = (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
      2'd1:    n = 2'd1;
      2'd2:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // Immediate bytes of the register/memory immediate forms.
  function automatic logic [1:0] data_count(input logic [7:0] op);
    logic [1:0] n;
    if (op[7:2] == OP6_GRP_IMM) n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
    else n = op[0] ? 2'd2 : 2'd1;
    return n;
  endfunction

  function automatic logic [2:0] full_length(input logic [7:0] op, input logic [7:0] modrm);
    logic [2:0] len;
    case (class_of(op))
      CLS_RM_REG:  len = 3'd2 + {1'b0, disp_count(modrm)};
      CLS_IMM_RM:  len = 3'd2 + {1'b0, disp_count(modrm)} + {1'b0, data_count(op)};
      CLS_IMM_REG: len = op[3] ? 3'd3 : 3'd2;
      CLS_MEM_ACC: len = 3'd3;
      CLS_ACC_MEM: len = 3'd3;
      CLS_IMM_ACC: len = op[0] ? 3'd3 : 3'd2;
      default:     len = 3'd2;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/x86dec_collect.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gathers the bytes of the current instruction and decides, as each byte
// arrives, whether the instruction is now complete.
module x86dec_collect (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     fire,
  input  wire [7:0]               code_byte,
  output x86dec_pkg::code_buf_t   view,
  output logic                    emit,
  output logic                    invalid_op
);

  x86dec_pkg::code_buf_t byte_buffer;
  logic [2:0] bytes_taken;
  logic [2:0] bytes_needed;
  logic       halted;

  logic [2:0] idx;
  logic [2:0] cnt;
  logic [2:0] needed_next;
  logic [3:0] cls;
  logic       done;

  always_comb begin
    idx = (bytes_taken >= 3'(x86dec_pkg::BUF_DEPTH)) ? 3'd0 : bytes_taken;
    view = byte_buffer;
    view[idx] = code_byte;
    cnt = idx + 3'd1;
    cls = x86dec_pkg::class_of(view[0]);
    invalid_op = 1'b0;
    needed_next = bytes_needed;
    if (cnt == 3'd1) begin
      if (cls == x86dec_pkg::CLS_INVALID) begin
        invalid_op = 1'b1;
      end else if (cls == x86dec_pkg::CLS_RM_REG || cls == x86dec_pkg::CLS_IMM_RM) begin
        // Length is not known until the mod-reg-rm byte is in.
        needed_next = 3'd2;
      end else begin
        needed_next = x86dec_pkg::full_length(view[0], view[1]);
      end
    end else if (cnt == 3'd2 &&
                 (cls == x86dec_pkg::CLS_RM_REG || cls == x86dec_pkg::CLS_IMM_RM)) begin
      needed_next = x86dec_pkg::full_length(view[0], view[1]);
    end
    done = invalid_op || (cnt >= needed_next);
    emit = fire && !halted && done;
  end

  always_ff @(posedge clk) begin
    if (fire && !halted) begin
      byte_buffer[idx] <= code_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_taken  <= 3'd0;
      bytes_needed <= 3'd0;
      halted       <= 1'b0;
    end else if (fire && !halted) begin
      if (done) begin
        bytes_taken  <= 3'd0;
        bytes_needed <= 3'd0;
        halted       <= invalid_op;
      end else begin
        bytes_taken  <= cnt;
        bytes_needed <= needed_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/x86dec_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Builds the decoded record of a complete instruction from its bytes.
module x86dec_decode (
  input  x86dec_pkg::code_buf_t   view,
  input  wire                     execute_enable,
  output x86dec_pkg::decode_rec_t rec,
  output x86dec_pkg::exec_req_t   exec_req
);

  logic [7:0] op;
  logic [7:0] m;
  logic [3:0] cls;
  logic [1:0] dn;
  logic [15:0] imm_rm;

  always_comb begin
    op  = view[0];
    m   = view[1];
    cls = x86dec_pkg::class_of(op);
    dn  = x86dec_pkg::disp_count(m);

    // Immediate of the register/memory forms sits right after the displacement.
    case (dn)
      2'd1:    imm_rm = (x86dec_pkg::data_count(op) == 2'd2) ? {view[4], view[3]}
                                                             : x86dec_pkg::sext8(view[3]);
      2'd2:    imm_rm = (x86dec_pkg::data_count(op) == 2'd2) ? {view[5], view[4]}
                                                             : x86dec_pkg::sext8(view[4]);
      default: imm_rm = (x86dec_pkg::data_count(op) == 2'd2) ? {view[3], view[2]}
                                                             : x86dec_pkg::sext8(view[2]);
    endcase

    rec = '0;
    rec.op_class = cls;
    exec_req = '0;

    case (cls)
      x86dec_pkg::CLS_RM_REG, x86dec_pkg::CLS_IMM_RM: begin
        rec.mode     = m[7:6];
        rec.rm_code  = m[2:0];
        rec.wide     = op[0];
        rec.reg_code = {op[0], m[5:3]};
        if (dn == 2'd1) rec.displacement = x86dec_pkg::sext8(view[2]);
        else if (dn == 2'd2) rec.displacement = {view[3], view[2]};
        if (cls == x86dec_pkg::CLS_RM_REG) begin
          rec.to_reg = op[1];
          if (op[7:2] == x86dec_pkg::OP6_ADD_RM) rec.alu_kind = x86dec_pkg::ALU_ADD;
          else if (op[7:2] == x86dec_pkg::OP6_SUB_RM) rec.alu_kind = x86dec_pkg::ALU_SUB;
          else if (op[7:2] == x86dec_pkg::OP6_CMP_RM) rec.alu_kind = x86dec_pkg::ALU_CMP;
          else rec.alu_kind = x86dec_pkg::ALU_MOV;
        end else begin
          rec.immediate = imm_rm;
          if (op[7:2] == x86dec_pkg::OP6_GRP_IMM) begin
            case (m[5:3])
              x86dec_pkg::GRP_ADD: rec.alu_kind = x86dec_pkg::ALU_ADD;
              x86dec_pkg::GRP_SUB: rec.alu_kind = x86dec_pkg::ALU_SUB;
              x86dec_pkg::GRP_CMP: rec.alu_kind = x86dec_pkg::ALU_CMP;
              default:             rec.alu_kind = x86dec_pkg::ALU_UNSUP;
            endcase
          end
        end
      end
      x86dec_pkg::CLS_IMM_REG: begin
        rec.wide      = op[3];
        rec.reg_code  = op[3:0];
        rec.to_reg    = 1'b1;
        rec.immediate = op[3] ? {view[2], view[1]} : x86dec_pkg::sext8(view[1]);
        exec_req.valid   = execute_enable;
        exec_req.wide    = op[3];
        exec_req.reg_sel = op[2:0];
        exec_req.data    = rec.immediate;
      end
      x86dec_pkg::CLS_MEM_ACC, x86dec_pkg::CLS_ACC_MEM: begin
        rec.wide         = op[0];
        rec.reg_code     = {op[0], 3'd0};
        rec.to_reg       = (cls == x86dec_pkg::CLS_MEM_ACC);
        rec.displacement = {view[2], view[1]};
      end
      x86dec_pkg::CLS_IMM_ACC: begin
        rec.wide      = op[0];
        rec.reg_code  = {op[0], 3'd0};
        rec.to_reg    = 1'b1;
        rec.immediate = op[0] ? {view[2], view[1]} : x86dec_pkg::sext8(view[1]);
        if (op[7:1] == x86dec_pkg::OP7_ADD_ACC) rec.alu_kind = x86dec_pkg::ALU_ADD;
        else if (op[7:1] == x86dec_pkg::OP7_SUB_ACC) rec.alu_kind = x86dec_pkg::ALU_SUB;
        else rec.alu_kind = x86dec_pkg::ALU_CMP;
      end
      x86dec_pkg::CLS_JCC: begin
        rec.jump_cond    = op[3:0];
        rec.displacement = x86dec_pkg::sext8(view[1]);
      end
      default: begin
        rec = '0;
        rec.op_class = x86dec_pkg::CLS_INVALID;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/x86dec_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none

// General register file written by MOV immediate-to-register. Byte
// registers 0..3 are the low halves of ax..bx and 4..7 the high halves.
module x86dec_regfile #(
  parameter int REG_COUNT = x86dec_pkg::REG_COUNT
) (
  input  wire                   clk,
  input  wire                   rst,
  input  x86dec_pkg::exec_req_t req,
  output logic [15:0]           reg_before,
  output logic [15:0]           reg_after
);

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [15:0] regs [REG_COUNT];
  logic [2:0]  sel;
  logic [IDX_W-1:0] idx;
  logic [15:0] old_val;
  logic [15:0] new_val;

  always_comb begin
    sel = req.wide ? req.reg_sel : {1'b0, req.reg_sel[1:0]};
    idx = sel[IDX_W-1:0];
    old_val = regs[idx];
    if (req.wide) new_val = req.data;
    else if (req.reg_sel[2]) new_val = {req.data[7:0], old_val[7:0]};
    else new_val = {old_val[15:8], req.data[7:0]};
    reg_before = req.valid ? old_val : 16'd0;
    reg_after  = req.valid ? new_val : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= 16'd0;
      end
    end else if (req.valid) begin
      regs[idx] <= new_val;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/x86_16bit_instruction_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial 8086 instruction decoder for MOV (all forms), ADD/SUB/CMP
// (register/memory, immediate and accumulator forms) and the sixteen
// conditional short jumps. Code bytes arrive one per transfer on the slave
// stream; the block takes one byte every clock, and a decoded record leaves
// on the master stream in the cycle after the transfer that brings the
// instruction's last byte, so the rate is one byte per cycle, limited only
// by the output register draining downstream.
// Instructions are 2 to 6 bytes long. An unknown opcode yields a record
// with op_class 7 and all other fields zero, after which all further bytes
// are taken and dropped until reset. With execute_enable set, MOV
// immediate-to-register writes the internal register file and the record
// reports the register's value before and after the write.
module x86_16bit_instruction_decoder #(
  parameter int REG_COUNT = x86dec_pkg::REG_COUNT
) (
  input  wire         clk,
  input  wire         rst,

  // Configuration: bit 0 is execute_enable.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_data,

  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] code_byte

  output logic        m_tvalid,
  input  wire         m_tready,
  // [3:0] op_class, [6:4] alu_kind, [7] to_reg, [8] wide, [10:9] mode,
  // [14:11] reg_code, [17:15] rm_code, [33:18] displacement,
  // [49:34] immediate, [53:50] jump_cond, [69:54] reg_before,
  // [85:70] reg_after, [87:86] zero
  output logic [87:0] m_tdata
);

  logic execute_enable;
  logic fire;
  logic emit;
  logic invalid_op;

  x86dec_pkg::code_buf_t   view;
  x86dec_pkg::decode_rec_t rec;
  x86dec_pkg::exec_req_t   dec_req;
  x86dec_pkg::exec_req_t   exec_req;
  logic [15:0] reg_before;
  logic [15:0] reg_after;

  logic        out_valid;
  logic [87:0] out_data;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      execute_enable <= 1'b0;
    end else if (cfg_valid) begin
      execute_enable <= cfg_data;
    end
  end

  // A new byte is taken whenever the output register is empty or is being
  // emptied in this same cycle.
  assign s_tready = !out_valid || m_tready;
  assign fire     = s_tvalid && s_tready;

  x86dec_collect u_collect (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .code_byte  (s_tdata),
    .view       (view),
    .emit       (emit),
    .invalid_op (invalid_op)
  );

  x86dec_decode u_decode (
    .view           (view),
    .execute_enable (execute_enable),
    .rec            (rec),
    .exec_req       (dec_req)
  );

  // Only a completed instruction may touch the register file.
  always_comb begin
    exec_req = dec_req;
    exec_req.valid = dec_req.valid && emit && !invalid_op;
  end

  x86dec_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk        (clk),
    .rst        (rst),
    .req        (exec_req),
    .reg_before (reg_before),
    .reg_after  (reg_after)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data <= {2'b00, reg_after, reg_before, rec.jump_cond, rec.immediate,
                   rec.displacement, rec.rm_code, rec.reg_code, rec.mode, rec.wide,
                   rec.to_reg, rec.alu_kind, rec.op_class};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the byte-serial 8086 decoder.
//
// An initial block lays out the code stream as whole instructions in
// code_q, and a clocked driver offers those bytes on the slave stream one
// transfer at a time. A clocked monitor watches both streams at the rising
// edge. Every accepted code byte runs through a bench-side decoder, which
// keeps its own byte gatherer, halt flag, register file and execute
// setting. Every record that this decoder completes goes to decoded_q. Each
// record that leaves the block is checked field by field against the
// oldest entry there.
//
// The run starts with a short directed stream that covers the corner
// encodings. After it come three random phases with different pacing on
// both sides. The execute setting is rewritten between phases, always
// while the block is idle. The last item is an unknown opcode, and a few
// bytes follow it that the halted block must swallow without a record.
module tb;
  import x86dec_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [1:0]  MOD_REG     = 2'd3;
  localparam logic [2:0]  RM_DIRECT   = 3'd6;

  // Bench-side record. The last field sits in the lowest bits, so a
  // record lines up with m_tdata[85:0].
  typedef struct packed {
    logic [15:0] reg_after;
    logic [15:0] reg_before;
    logic [3:0]  jump_cond;
    logic [15:0] immediate;
    logic [15:0] displacement;
    logic [2:0]  rm_code;
    logic [3:0]  reg_code;
    logic [1:0]  mode;
    logic        wide;
    logic        to_reg;
    logic [2:0]  alu_kind;
    logic [3:0]  op_class;
  } dec_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;

  // Stimulus and expectations.
  logic [7:0]  code_q [$];
  dec_result_t decoded_q [$];
  logic        in_xfer;
  int unsigned src_idle;
  int unsigned snk_idle;

  // State of the bench-side decoder.
  logic [7:0]  ibytes [6];
  int unsigned taken;
  int unsigned needed;
  logic        halted;
  logic        exec_on;
  logic [15:0] regs [REG_COUNT];

  // Counters for the verdict and the summary.
  int unsigned mismatches;
  int unsigned quiet;
  int unsigned n_bytes;
  int unsigned n_records;
  int unsigned n_exec;
  int unsigned n_unsup;

  x86_16bit_instruction_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Decoding rules
  // ---------------------------------------------------------------------

  function automatic logic [3:0] op_class_of(input logic [7:0] op);
    if (op[7:2] == OP6_MOV_RM || op[7:2] == OP6_ADD_RM || op[7:2] == OP6_SUB_RM ||
        op[7:2] == OP6_CMP_RM)
      return CLS_RM_REG;
    if (op[7:1] == OP7_MOV_IRM || op[7:2] == OP6_GRP_IMM)
      return CLS_IMM_RM;
    if (op[7:4] == OP4_MOV_IREG)
      return CLS_IMM_REG;
    if (op[7:1] == OP7_MEM_ACC)
      return CLS_MEM_ACC;
    if (op[7:1] == OP7_ACC_MEM)
      return CLS_ACC_MEM;
    if (op[7:1] == OP7_ADD_ACC || op[7:1] == OP7_SUB_ACC || op[7:1] == OP7_CMP_ACC)
      return CLS_IMM_ACC;
    if (op[7:4] == OP4_JCC)
      return CLS_JCC;
    return CLS_INVALID;
  endfunction

  // Displacement bytes after a mod-reg-rm byte. Mod 00 with r/m 110 is a
  // direct 16-bit address rather than a register-based formula.
  function automatic int unsigned addr_bytes(input logic [7:0] modrm);
    if (modrm[7:6] == MOD_REG)
      return 0;
    if (modrm[7:6] == 2'd0)
      return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
    return int'(modrm[7:6]);
  endfunction

  // Immediate bytes of the register/memory immediate forms. In the ALU
  // group a set s bit shrinks word data to one sign-extended byte.
  function automatic int unsigned imm_bytes(input logic [7:0] op);
    return (op[0] && !(op[7:2] == OP6_GRP_IMM && op[1])) ? 2 : 1;
  endfunction

  function automatic int unsigned instr_len(input logic [7:0] op, input logic [7:0] modrm);
    case (op_class_of(op))
      CLS_RM_REG:               return 2 + addr_bytes(modrm);
      CLS_IMM_RM:               return 2 + addr_bytes(modrm) + imm_bytes(op);
      CLS_IMM_REG:              return op[3] ? 3 : 2;
      CLS_MEM_ACC, CLS_ACC_MEM: return 3;
      CLS_IMM_ACC:              return op[0] ? 3 : 2;
      default:                  return 2;
    endcase
  endfunction

  function automatic logic [15:0] widen8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  // Takes one code byte. When the byte completes an instruction, the record
  // the block should send is queued in decoded_q.
  task automatic decode_byte(input logic [7:0] code);
    dec_result_t r;
    logic [7:0]  op;
    logic [7:0]  modrm;
    logic [3:0]  cls;
    logic [2:0]  rsel;
    int unsigned nd;
    int unsigned p;
    int unsigned idx;
    logic [15:0] old_val;
    logic [15:0] new_val;

    if (halted)
      return;
    ibytes[taken] = code;
    taken++;
    op  = ibytes[0];
    cls = op_class_of(op);
    r   = '0;

    if (taken == 1) begin
      if (cls == CLS_INVALID) begin
        // An unknown opcode is reported once, and the block then stops.
        halted = 1'b1;
        taken  = 0;
        r.op_class = CLS_INVALID;
        decoded_q.push_back(r);
        return;
      end
      // Forms with a mod-reg-rm byte learn their length from that byte.
      needed = (cls == CLS_RM_REG || cls == CLS_IMM_RM) ? 2 : instr_len(op, 8'h00);
    end else if (taken == 2 && (cls == CLS_RM_REG || cls == CLS_IMM_RM)) begin
      needed = instr_len(op, ibytes[1]);
    end
    if (taken < needed)
      return;

    r.op_class = cls;
    case (cls)
      CLS_RM_REG, CLS_IMM_RM: begin
        modrm      = ibytes[1];
        nd         = addr_bytes(modrm);
        r.mode     = modrm[7:6];
        r.rm_code  = modrm[2:0];
        r.wide     = op[0];
        r.reg_code = {op[0], modrm[5:3]};
        if (nd == 1)
          r.displacement = widen8(ibytes[2]);
        else if (nd == 2)
          r.displacement = {ibytes[3], ibytes[2]};
        if (cls == CLS_RM_REG) begin
          r.to_reg = op[1];
          if (op[7:2] == OP6_ADD_RM)
            r.alu_kind = ALU_ADD;
          else if (op[7:2] == OP6_SUB_RM)
            r.alu_kind = ALU_SUB;
          else if (op[7:2] == OP6_CMP_RM)
            r.alu_kind = ALU_CMP;
          else
            r.alu_kind = ALU_MOV;
        end else begin
          p = 2 + nd;
          r.immediate = (imm_bytes(op) == 2) ? {ibytes[p + 1], ibytes[p]} : widen8(ibytes[p]);
          if (op[7:2] == OP6_GRP_IMM) begin
            // The reg field picks the group member; only three are decoded.
            case (modrm[5:3])
              GRP_ADD: r.alu_kind = ALU_ADD;
              GRP_SUB: r.alu_kind = ALU_SUB;
              GRP_CMP: r.alu_kind = ALU_CMP;
              default: r.alu_kind = ALU_UNSUP;
            endcase
            if (r.alu_kind == ALU_UNSUP)
              n_unsup++;
          end
        end
      end
      CLS_IMM_REG: begin
        rsel        = op[2:0];
        r.wide      = op[3];
        r.reg_code  = {op[3], rsel};
        r.to_reg    = 1'b1;
        r.immediate = op[3] ? {ibytes[2], ibytes[1]} : widen8(ibytes[1]);
        if (exec_on) begin
          // Byte registers al..bl live in the low half of ax..bx and
          // ah..bh in the high half; the other half must survive.
          idx     = op[3] ? int'(rsel) : int'(rsel[1:0]);
          old_val = regs[idx];
          if (op[3])
            new_val = r.immediate;
          else if (rsel[2])
            new_val = {r.immediate[7:0], old_val[7:0]};
          else
            new_val = {old_val[15:8], r.immediate[7:0]};
          regs[idx]    = new_val;
          r.reg_before = old_val;
          r.reg_after  = new_val;
          n_exec++;
        end
      end
      CLS_MEM_ACC, CLS_ACC_MEM: begin
        r.wide         = op[0];
        r.reg_code     = {op[0], 3'd0};
        r.to_reg       = (cls == CLS_MEM_ACC);
        r.displacement = {ibytes[2], ibytes[1]};
      end
      CLS_IMM_ACC: begin
        r.wide      = op[0];
        r.reg_code  = {op[0], 3'd0};
        r.to_reg    = 1'b1;
        r.immediate = op[0] ? {ibytes[2], ibytes[1]} : widen8(ibytes[1]);
        if (op[7:1] == OP7_ADD_ACC)
          r.alu_kind = ALU_ADD;
        else if (op[7:1] == OP7_SUB_ACC)
          r.alu_kind = ALU_SUB;
        else
          r.alu_kind = ALU_CMP;
      end
      default: begin
        r.jump_cond    = op[3:0];
        r.displacement = widen8(ibytes[1]);
      end
    endcase
    taken  = 0;
    needed = 0;
    decoded_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("record %0d: %s expected %h, got %h", n_records, name, want, got);
    end
  endtask

  task automatic check_record(input dec_result_t want, input logic [87:0] raw);
    dec_result_t got;
    got = raw[85:0];
    cmp_field("op_class", want.op_class, got.op_class);
    cmp_field("alu_kind", want.alu_kind, got.alu_kind);
    cmp_field("to_reg", want.to_reg, got.to_reg);
    cmp_field("wide", want.wide, got.wide);
    cmp_field("mode", want.mode, got.mode);
    cmp_field("reg_code", want.reg_code, got.reg_code);
    cmp_field("rm_code", want.rm_code, got.rm_code);
    cmp_field("displacement", want.displacement, got.displacement);
    cmp_field("immediate", want.immediate, got.immediate);
    cmp_field("jump_cond", want.jump_cond, got.jump_cond);
    cmp_field("reg_before", want.reg_before, got.reg_before);
    cmp_field("reg_after", want.reg_after, got.reg_after);
    cmp_field("padding", 16'd0, {14'd0, raw[87:86]});
  endtask

  // Monitor. The outgoing record is checked before the incoming byte is
  // decoded: the record is registered, so a record that completes at this edge
  // cannot also leave at this edge.
  always @(posedge clk) begin : monitor
    dec_result_t want;
    if (rst) begin
      taken   = 0;
      needed  = 0;
      halted  = 1'b0;
      exec_on = 1'b0;
      for (int i = 0; i < REG_COUNT; i++)
        regs[i] = 16'd0;
    end else begin
      if (cfg_valid && cfg_ready)
        exec_on = cfg_data;
      if (m_tvalid && m_tready) begin
        n_records++;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record %0d arrived with none expected: %h", n_records, m_tdata);
        end else begin
          want = decoded_q.pop_front();
          check_record(want, m_tdata);
        end
      end
      if (s_tvalid && s_tready) begin
        n_bytes++;
        decode_byte(s_tdata);
      end
    end
    in_xfer <= !rst && s_tvalid && s_tready;
  end

  // Watchdog: ends the run when neither stream nor the configuration
  // channel has completed a transfer for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Both stream sides change only at the falling edge. A byte stays
  // offered until the monitor has seen its transfer.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (in_xfer || !s_tvalid) begin
        if (code_q.size() == 0 || $urandom_range(99) < src_idle) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= code_q.pop_front();
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic write_exec(input logic en);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Holds off until every queued byte has been taken and every expected
  // record has come back, then lets the pipeline settle.
  task automatic drain();
    while (code_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Queues whole, well-formed instructions with random content until at
  // least count bytes are waiting.
  task automatic push_random(input int unsigned count);
    logic [7:0]  op;
    logic [7:0]  modrm;
    int unsigned len;
    int unsigned added;
    added = 0;
    while (added < count) begin
      op = 8'($urandom_range(255));
      while (op_class_of(op) == CLS_INVALID)
        op = 8'($urandom_range(255));
      modrm = 8'($urandom_range(255));
      len   = instr_len(op, modrm);
      code_q.push_back(op);
      code_q.push_back(modrm);
      for (int i = 2; i < len; i++)
        code_q.push_back(8'($urandom_range(255)));
      added += len;
    end
  endtask

  // Directed stream: direct addressing, the unsupported group member with a
  // 16-bit displacement and word data, s-bit sign extension, extreme
  // immediates, a byte write into a high half, accumulator forms and a
  // backward jump.
  localparam logic [7:0] DIRECTED [27] = '{
    8'h2B, 8'h06, 8'h34, 8'h12,
    8'h81, 8'h96, 8'h00, 8'h80, 8'hFF, 8'h7F,
    8'h83, 8'h7F, 8'h80, 8'hFF,
    8'hB8, 8'hFF, 8'hFF,
    8'hB4, 8'h80,
    8'hA2, 8'h00, 8'h80,
    8'h05, 8'h01, 8'h80,
    8'h7F, 8'h80
  };

  initial begin
    logic [7:0] bad_op;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = 8'd0;
    m_tready   = 1'b0;
    src_idle   = 22;
    snk_idle   = 61;
    mismatches = 0;
    quiet      = 0;
    n_bytes    = 0;
    n_records  = 0;
    n_exec     = 0;
    n_unsup    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_exec(1'b1);
    foreach (DIRECTED[i])
      code_q.push_back(DIRECTED[i]);
    drain();

    // Sender mostly busy, receiver often stalled. The sender pauses halfway
    // until every record is back, and execution is switched on there.
    write_exec(1'b0);
    push_random(300);
    drain();
    write_exec(1'b1);
    push_random(300);
    drain();

    // Sender often idle, receiver mostly ready.
    src_idle = 61;
    snk_idle = 22;
    write_exec(1'b0);
    push_random(300);
    drain();

    // Full rate on both sides.
    src_idle = 0;
    snk_idle = 0;
    write_exec(1'b1);
    push_random(320);
    drain();

    // An unknown opcode ends decoding. The bytes after it must be taken
    // and dropped without a record.
    bad_op = 8'($urandom_range(255));
    while (op_class_of(bad_op) != CLS_INVALID)
      bad_op = 8'($urandom_range(255));
    code_q.push_back(bad_op);
    code_q.push_back(8'hB8);
    code_q.push_back(8'h12);
    code_q.push_back(8'h34);
    code_q.push_back(8'($urandom_range(255)));
    drain();
    repeat (8) @(negedge clk);

    if (decoded_q.size() != 0)
      mismatches++;
    $display("Covered %0d code bytes and %0d records: %0d executed register writes,",
             n_bytes, n_records, n_exec);
    $display("%0d unsupported group members, a halt on opcode %h, three pacing phases.",
             n_unsup, bad_op);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
